// File: rtl/sitda_pkg.sv
package sitda_pkg;

	// default width of the converted integer
	localparam int DEF_VALUE_BITS = 32;

	// magnitude bits folded into the decimal register per conversion cycle
	localparam int DABBLE_BITS = 4;

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic find;
		logic step;
		logic sel_sign;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic neg;
		logic idx_zero;
	} dp_sts_t;

	// conversion cycles for a given integer width
	function automatic int num_steps(input int value_bits);
		return (value_bits + DABBLE_BITS - 1) / DABBLE_BITS;
	endfunction

endpackage

// File: rtl/sitda_ctrl.sv
module sitda_ctrl
	import sitda_pkg::*;
#(
	parameter int STEPS = num_steps(DEF_VALUE_BITS)
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd,
	output logic     busy,
	output logic     strobe
);

	localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

	state_t          state_q;
	state_t          state_d;
	logic [CW-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CW'(STEPS - 1)) state_d = ST_FIND;
			end
			ST_FIND: begin
				state_d = sts.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (sts.idx_zero) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		strobe = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
			end
			ST_SIGN: begin
				cmd.sel_sign = 1'b1;
				strobe       = 1'b1;
			end
			ST_DIGIT: begin
				cmd.step = 1'b1;
				strobe   = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/sitda_datapath.sv
module sitda_datapath
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  ctl_cmd_t              cmd,
	input  logic [VALUE_BITS-1:0] value,
	output dp_sts_t               sts,
	output logic [5:0]            char_code,
	output logic                  last_char
);

	localparam int STEPS = num_steps(VALUE_BITS);
	localparam int MAGW  = STEPS * DABBLE_BITS;
	// decimal digits of 2^(VALUE_BITS-1), log10(2) ~ 0.30103
	localparam int ND    = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int BW    = ND * 4;
	localparam int IW    = (ND > 1) ? $clog2(ND) : 1;

	logic [MAGW-1:0]       mag_q;
	logic                  neg_q;
	logic [BW-1:0]         bcd_q;
	logic [IW-1:0]         idx_q;
	logic [VALUE_BITS-1:0] mag_in;
	logic [BW-1:0]         bcd_next;
	logic [IW-1:0]         lead;
	logic [3:0]            digit;

	// two's complement magnitude, the most negative value stays exact as unsigned
	assign mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

	// shift-add-3 over several magnitude bits
	always_comb begin
		logic [BW-1:0] b;
		b = bcd_q;
		for (int k = 0; k < DABBLE_BITS; k++) begin
			for (int d = 0; d < ND; d++) begin
				if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
			end
			b = {b[BW-2:0], mag_q[MAGW-1-k]};
		end
		bcd_next = b;
	end

	// most significant nonzero digit, zero keeps index 0
	always_comb begin
		lead = '0;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) lead = IW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= MAGW'(mag_in);
			neg_q <= value[VALUE_BITS-1];
			bcd_q <= '0;
		end else if (cmd.conv) begin
			mag_q <= mag_q << DABBLE_BITS;
			bcd_q <= bcd_next;
		end
		if (cmd.find) begin
			idx_q <= lead;
		end else if (cmd.step) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	assign digit        = bcd_q[idx_q*4 +: 4];
	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign char_code    = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digit});
	assign last_char    = cmd.step && (idx_q == '0);

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// signed integer to decimal ascii text
//
// input: pulse start with value (two's complement, VALUE_BITS wide) while busy
// is low; the transaction is taken on that clock edge and busy rises on the
// next cycle. output: one character per cycle on char_code, marked by strobe,
// most significant first; a leading '-' for negative values, last_char high on
// the final character. the receiver cannot stall, so every strobed character
// must be taken in its cycle.
// sequence: conversion (the shift-add-3 loop folding four magnitude bits per
// cycle), locating the leading digit, then the characters, then a return to
// idle with busy low. a new number is taken only from idle, never while the
// characters of the last one are still coming out.
// reset: asynchronous, active low; the controller returns to idle, no
// characters are pending and busy is low.
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  busy,
	output logic                  strobe,
	output logic [5:0]            char_code,
	output logic                  last_char
);

	localparam int STEPS = num_steps(VALUE_BITS);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// sequencing: idle, convert, find leading digit, sign, digits
	sitda_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	// magnitude, bcd register and character selection
	sitda_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.char_code (char_code),
		.last_char (last_char)
	);

	// a taken transaction starts conversion, never output in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe))
		else $error("accepted transaction did not start conversion");

	// the final character frees the block
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_char) |=> !busy)
		else $error("block still busy after final character");

	// characters only come out while busy
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("character strobed while idle");

	// every character is a minus or a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHAR_MINUS ||
			(char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 6'd9)))
		else $error("character code out of range");

endmodule

// File: verif/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
	import sitda_pkg::*;

	// one character of the decimal text as it leaves the block
	typedef struct packed {
		logic [5:0] code;
		logic       last;
	} text_char_t;

	// directed row: the number and, where it is obvious, its text
	// an empty text means the row is checked against the predictor
	typedef struct {
		logic [31:0] num;
		string       text;
	} directed_row_t;

	localparam int N_DIRECTED  = 22;
	localparam int N_RANDOM    = 350;
	localparam int MAX_GAP     = 12;
	localparam int DRAIN_CYCLES = 40;
	localparam int DRAIN_LIMIT  = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [31:0] value;
	logic        busy;
	logic        strobe;
	logic [5:0]  char_code;
	logic        last_char;

	// characters still owed by the block, oldest first
	text_char_t pending_chars[$];
	int         mismatch_count;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{32'h0000_0000, "0"},
		'{32'h0000_0001, "1"},
		'{32'hFFFF_FFFF, "-1"},
		'{32'h0000_0009, "9"},
		'{32'h0000_000A, "10"},
		'{32'hFFFF_FFF6, "-10"},
		'{32'h7FFF_FFFF, "2147483647"},
		'{32'h8000_0000, "-2147483648"},
		'{32'h8000_0001, "-2147483647"},
		'{32'h3B9A_CA00, "1000000000"},
		'{32'hC465_3600, "-1000000000"},
		'{32'h3B9A_C9FF, "999999999"},
		'{32'hC465_3601, "-999999999"},
		'{32'h0000_0063, ""},
		'{32'h0000_0064, ""},
		'{32'hFFFF_FF9C, ""},
		'{32'h5555_5555, ""},
		'{32'hAAAA_AAAA, ""},
		'{32'h0000_3039, ""},
		'{32'hFFFF_E57B, ""},
		'{32'h7FFF_FFFE, ""},
		'{32'h8000_000A, ""}
	};

	signed_int_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	// 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decimal text of a two's complement number, sign first, last mark on the final digit
	function automatic void decimal_text(input logic [31:0] num, ref text_char_t chars[$]);
		logic [31:0] magnitude;
		logic [3:0]  digits[$];
		text_char_t  one;
		chars.delete();
		// unsigned negation, so the most negative number gives 2^31 without overflow
		magnitude = num[31] ? (32'd0 - num) : num;
		do begin
			digits.push_front(4'(magnitude % 32'd10));
			magnitude = magnitude / 32'd10;
		end while (magnitude != 0);
		if (num[31]) begin
			one.code = CHAR_MINUS;
			one.last = 1'b0;
			chars.push_back(one);
		end
		foreach (digits[i]) begin
			one.code = CHAR_ZERO + 6'(digits[i]);
			one.last = (i == digits.size() - 1);
			chars.push_back(one);
		end
	endfunction

	// typed-in text of a directed row turned into characters
	function automatic void text_to_chars(input string text, ref text_char_t chars[$]);
		logic [7:0] ascii;
		text_char_t one;
		chars.delete();
		for (int i = 0; i < text.len(); i++) begin
			ascii = text[i];
			one.code = ascii[5:0];
			one.last = (i == text.len() - 1);
			chars.push_back(one);
		end
	endfunction

	function automatic longint ten_to(input int n);
		longint p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// random number shaped to reach every digit count, both signs and the edges
	function automatic logic [31:0] random_number();
		longint lo;
		longint hi;
		longint magnitude;
		int     ndig;
		bit     neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return $urandom;
			end
			3, 4, 5, 6: begin
				// uniform over digit count, then uniform within that count
				ndig = $urandom_range(1, 10);
				lo = (ndig == 1) ? 0 : ten_to(ndig - 1);
				hi = ten_to(ndig) - 1;
				if (ndig == 10) begin
					hi = neg ? 64'd2147483648 : 64'd2147483647;
				end
				magnitude = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
			end
			7: begin
				// a power of ten or one either side of it
				magnitude = ten_to($urandom_range(0, 9)) + longint'($urandom_range(0, 2)) - 1;
			end
			8: begin
				magnitude = longint'($urandom_range(0, 20));
			end
			default: begin
				// close to the positive or negative limit
				if (neg) begin
					return 32'h8000_0000 + $urandom_range(0, 15);
				end
				return 32'h7FFF_FFFF - $urandom_range(0, 15);
			end
		endcase
		return neg ? 32'(-magnitude) : 32'(magnitude);
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endfunction

	// one transaction: optional idle gap, then start held until the block takes it
	// start stays high across back-to-back transactions when the gap is zero
	task automatic send_number(input logic [31:0] num, input string text, input int gap);
		text_char_t chars[$];
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= num;
		do @(posedge clk); while (busy);
		// taken at this edge
		if (text.len() > 0) begin
			text_to_chars(text, chars);
		end else begin
			decimal_text(num, chars);
		end
		foreach (chars[i]) pending_chars.push_back(chars[i]);
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// every strobed character is checked against the oldest one owed
	always @(posedge clk) begin : char_check
		text_char_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				note_failure($sformatf("unexpected character code %0d last %0b",
					char_code, last_char));
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code || last_char !== want.last) begin
					note_failure($sformatf("character code %0d last %0b, expected code %0d last %0b",
						char_code, last_char, want.code, want.last));
				end
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int gap;
		int waited;
		mismatch_count = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table: extremes, zero, sign boundaries, digit-count boundaries
		foreach (directed_rows[i]) begin
			send_number(directed_rows[i].num, directed_rows[i].text, $urandom_range(0, MAX_GAP));
		end
		// let the block run dry once before random traffic
		wait_for_drain();

		for (int n = 0; n < N_RANDOM; n++) begin
			// every fourth stretch of forty transactions runs with no gaps
			if ((n / 40) % 4 == 3) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
			end
			// now and then the sender holds off until all text has come out
			if (n % 97 == 50) begin
				wait_for_drain();
			end
			send_number(random_number(), "", gap);
		end
		start <= 1'b0;

		waited = 0;
		while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			note_failure($sformatf("%0d characters never came out", pending_chars.size()));
		end

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin : watchdog
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
